/* src/qta_pkg.sv */
// Shared types, constants and arithmetic helpers for the quaternion to affine matrix unit.
`default_nettype none

package qta_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned PROD_W = 64;
	localparam int unsigned RSUM_W = 65;
	localparam int unsigned TSUM_W = 66;
	localparam int unsigned ROT_FRAC_SHIFT = 29;
	localparam int unsigned TRANS_FRAC_SHIFT = 30;
	localparam int unsigned IN_DATA_W = 7 * WORD_W;
	localparam int unsigned OUT_DATA_W = 12 * WORD_W;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [RSUM_W-1:0] rsum_t;
	typedef logic signed [TSUM_W-1:0] tsum_t;

	// Rotation matrix, row-major: element 3*row+col.
	typedef word_t [8:0] rot9_t;
	// Point or translation, element 0 is x.
	typedef word_t [2:0] vec3_t;

	typedef struct packed {
		word_t w;
		word_t x;
		word_t y;
		word_t z;
	} quat_t;

	typedef struct packed {
		prod_t xx;
		prod_t yy;
		prod_t zz;
		prod_t xy;
		prod_t xz;
		prod_t yz;
		prod_t wx;
		prod_t wy;
		prod_t wz;
	} qprod_t;

	// Half an LSB of the Q1.30 result at 2^-59 scale, and 1.0 plus that half.
	localparam rsum_t ROT_HALF = rsum_t'(1) <<< (ROT_FRAC_SHIFT - 1);
	localparam rsum_t ROT_ONE_HALF = (rsum_t'(1) <<< 59) + ROT_HALF;
	// Half an LSB of the Q16.16 result at 2^-46 scale.
	localparam tsum_t TRANS_HALF = tsum_t'(1) <<< (TRANS_FRAC_SHIFT - 1);

	localparam tsum_t SAT_MAX = tsum_t'(64'sd2147483647);
	localparam tsum_t SAT_MIN = tsum_t'(-64'sd2147483648);

	function automatic rsum_t ext_prod(input prod_t p);
		return rsum_t'(p);
	endfunction

	// Clamp a wide signed value to the 32-bit two's complement range.
	function automatic word_t sat_word(input tsum_t v);
		word_t r;
		if (v > SAT_MAX) begin
			r = word_t'(32'sh7FFF_FFFF);
		end else if (v < SAT_MIN) begin
			r = word_t'(32'sh8000_0000);
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/quaternion_to_affine_matrix_unit.sv */
// Top level of the quaternion to affine matrix unit: stream ports and pipeline wiring.
//
// Each slave-side word carries one quaternion (Q1.30) and one rotation centre
// (Q16.16). Each master-side word carries the 3x4 affine matrix: nine Q1.30
// rotation entries from the doubled-product formulas (the quaternion is used
// as given, not normalized) and a Q16.16 translation equal to the centre minus
// the rotated centre, so the matrix rotates about that centre. Every output is
// rounded half up and saturated to 32 bits.
// The datapath is a six-stage pipeline: quaternion products, entry sums,
// entry rounding, centre products, translation sums, and translation rounding
// into the output register. An accepted word moves through the stage registers
// in that order and is offered from the output register; the pipeline holds up
// to six words. One word can be accepted every cycle while the receiver keeps
// taking words; throughput is then one word per cycle, set by the nine
// parallel multipliers in each of the two product stages.
// Each stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up and s_axis_tready stays high
// while any stage is free. When the receiver holds m_axis_tready low, the
// output word holds steady and the pipeline fills, after which s_axis_tready
// drops; nothing is lost or repeated. Reset clears all valid bits; the unit
// keeps no other state.
`default_nettype none

module quaternion_to_affine_matrix_unit (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	// From bit 0 up: q_w, q_x, q_y, q_z, centre_x, centre_y, centre_z (32 bits each).
	input  wire  [qta_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	// From bit 0 up: rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20,
	// rot_21, rot_22, trans_x, trans_y, trans_z (32 bits each).
	output logic [qta_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

	qta_pkg::quat_t  quat;
	qta_pkg::vec3_t  centre;
	qta_pkg::qprod_t prod;
	qta_pkg::vec3_t  centre_a;
	qta_pkg::vec3_t  centre_b;
	qta_pkg::rot9_t  rot_b;
	qta_pkg::rot9_t  rot_out;
	qta_pkg::vec3_t  trans;
	logic            valid_a;
	logic            ready_a;
	logic            valid_b;
	logic            ready_b;

	// Unpack the incoming word into its fields.
	assign quat.w = s_axis_tdata[31:0];
	assign quat.x = s_axis_tdata[63:32];
	assign quat.y = s_axis_tdata[95:64];
	assign quat.z = s_axis_tdata[127:96];
	assign centre[0] = s_axis_tdata[159:128];
	assign centre[1] = s_axis_tdata[191:160];
	assign centre[2] = s_axis_tdata[223:192];

	// Stage 1: pairwise quaternion products.
	qta_quat_mul u_quat_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.quat       (quat),
		.centre     (centre),
		.out_valid  (valid_a),
		.out_ready  (ready_a),
		.prod       (prod),
		.centre_out (centre_a)
	);

	// Stages 2 and 3: the nine rotation entries.
	qta_rot_round u_rot_round (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (valid_a),
		.in_ready   (ready_a),
		.prod       (prod),
		.centre     (centre_a),
		.out_valid  (valid_b),
		.out_ready  (ready_b),
		.rot        (rot_b),
		.centre_out (centre_b)
	);

	// Stages 4 to 6: translation and the output register.
	qta_trans u_trans (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_b),
		.in_ready  (ready_b),
		.rot       (rot_b),
		.centre    (centre_b),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.rot_out   (rot_out),
		.trans     (trans)
	);

	// Pack the matrix, rotation entries in the low bits, row-major.
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			m_axis_tdata[i*qta_pkg::WORD_W +: qta_pkg::WORD_W] = rot_out[i];
		end
		for (int i = 0; i < 3; i++) begin
			m_axis_tdata[(9+i)*qta_pkg::WORD_W +: qta_pkg::WORD_W] = trans[i];
		end
	end

endmodule

`default_nettype wire

/* src/qta_quat_mul.sv */
// Stage 1: the nine pairwise quaternion products, registered.
`default_nettype none

module qta_quat_mul (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  qta_pkg::quat_t    quat,
	input  qta_pkg::vec3_t    centre,
	output logic              out_valid,
	input  wire               out_ready,
	output qta_pkg::qprod_t   prod,
	output qta_pkg::vec3_t    centre_out
);

	logic            v_s1;
	logic            en_s1;
	qta_pkg::qprod_t prod_s1;
	qta_pkg::vec3_t  centre_s1;

	assign en_s1 = !v_s1 || out_ready;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			prod_s1.xx <= quat.x * quat.x;
			prod_s1.yy <= quat.y * quat.y;
			prod_s1.zz <= quat.z * quat.z;
			prod_s1.xy <= quat.x * quat.y;
			prod_s1.xz <= quat.x * quat.z;
			prod_s1.yz <= quat.y * quat.z;
			prod_s1.wx <= quat.w * quat.x;
			prod_s1.wy <= quat.w * quat.y;
			prod_s1.wz <= quat.w * quat.z;
			centre_s1 <= centre;
		end
	end

	assign out_valid = v_s1;
	assign prod = prod_s1;
	assign centre_out = centre_s1;

endmodule

`default_nettype wire

/* src/qta_rot_round.sv */
// Stages 2 and 3: rotation entry sums, then rounding and saturation to Q1.30.
`default_nettype none

module qta_rot_round (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  qta_pkg::qprod_t   prod,
	input  qta_pkg::vec3_t    centre,
	output logic              out_valid,
	input  wire               out_ready,
	output qta_pkg::rot9_t    rot,
	output qta_pkg::vec3_t    centre_out
);

	logic            v_s2;
	logic            v_s3;
	logic            en_s2;
	logic            en_s3;
	qta_pkg::rsum_t  sum_s2 [9];
	qta_pkg::vec3_t  centre_s2;
	qta_pkg::rot9_t  rot_s3;
	qta_pkg::vec3_t  centre_s3;

	assign en_s3 = !v_s3 || out_ready;
	assign en_s2 = !v_s2 || en_s3;
	assign in_ready = en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s2) begin
				v_s2 <= in_valid;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Sums carry the rounding half so the next stage only shifts and clamps.
	always_ff @(posedge clk) begin
		if (en_s2 && in_valid) begin
			sum_s2[0] <= qta_pkg::ROT_ONE_HALF - qta_pkg::ext_prod(prod.yy)
				- qta_pkg::ext_prod(prod.zz);
			sum_s2[1] <= qta_pkg::ext_prod(prod.xy) - qta_pkg::ext_prod(prod.wz)
				+ qta_pkg::ROT_HALF;
			sum_s2[2] <= qta_pkg::ext_prod(prod.xz) + qta_pkg::ext_prod(prod.wy)
				+ qta_pkg::ROT_HALF;
			sum_s2[3] <= qta_pkg::ext_prod(prod.xy) + qta_pkg::ext_prod(prod.wz)
				+ qta_pkg::ROT_HALF;
			sum_s2[4] <= qta_pkg::ROT_ONE_HALF - qta_pkg::ext_prod(prod.xx)
				- qta_pkg::ext_prod(prod.zz);
			sum_s2[5] <= qta_pkg::ext_prod(prod.yz) - qta_pkg::ext_prod(prod.wx)
				+ qta_pkg::ROT_HALF;
			sum_s2[6] <= qta_pkg::ext_prod(prod.xz) - qta_pkg::ext_prod(prod.wy)
				+ qta_pkg::ROT_HALF;
			sum_s2[7] <= qta_pkg::ext_prod(prod.yz) + qta_pkg::ext_prod(prod.wx)
				+ qta_pkg::ROT_HALF;
			sum_s2[8] <= qta_pkg::ROT_ONE_HALF - qta_pkg::ext_prod(prod.xx)
				- qta_pkg::ext_prod(prod.yy);
			centre_s2 <= centre;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			for (int i = 0; i < 9; i++) begin
				rot_s3[i] <= qta_pkg::sat_word(qta_pkg::tsum_t'(sum_s2[i]
					>>> qta_pkg::ROT_FRAC_SHIFT));
			end
			centre_s3 <= centre_s2;
		end
	end

	assign out_valid = v_s3;
	assign rot = rot_s3;
	assign centre_out = centre_s3;

endmodule

`default_nettype wire

/* src/qta_trans.sv */
// Stages 4 to 6: rotated centre products, translation sums, rounding and output register.
`default_nettype none

module qta_trans (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  qta_pkg::rot9_t    rot,
	input  qta_pkg::vec3_t    centre,
	output logic              out_valid,
	input  wire               out_ready,
	output qta_pkg::rot9_t    rot_out,
	output qta_pkg::vec3_t    trans
);

	logic            v_s4;
	logic            v_s5;
	logic            v_s6;
	logic            en_s4;
	logic            en_s5;
	logic            en_s6;
	qta_pkg::prod_t  prod_s4 [9];
	qta_pkg::vec3_t  centre_s4;
	qta_pkg::rot9_t  rot_s4;
	qta_pkg::tsum_t  tsum_s5 [3];
	qta_pkg::rot9_t  rot_s5;
	qta_pkg::vec3_t  trans_s6;
	qta_pkg::rot9_t  rot_s6;

	assign en_s6 = !v_s6 || out_ready;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign in_ready = en_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s4) begin
				v_s4 <= in_valid;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
			if (en_s6) begin
				v_s6 <= v_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && in_valid) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s4[3*i+j] <= rot[3*i+j] * centre[j];
				end
			end
			centre_s4 <= centre;
			rot_s4 <= rot;
		end
	end

	// Centre moved to the 2^-46 scale of the products, minus the rotated centre.
	always_ff @(posedge clk) begin
		if (en_s5 && v_s4) begin
			for (int i = 0; i < 3; i++) begin
				tsum_s5[i] <= (qta_pkg::tsum_t'(centre_s4[i]) <<< qta_pkg::TRANS_FRAC_SHIFT)
					- qta_pkg::tsum_t'(prod_s4[3*i])
					- qta_pkg::tsum_t'(prod_s4[3*i+1])
					- qta_pkg::tsum_t'(prod_s4[3*i+2])
					+ qta_pkg::TRANS_HALF;
			end
			rot_s5 <= rot_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6 && v_s5) begin
			for (int i = 0; i < 3; i++) begin
				trans_s6[i] <= qta_pkg::sat_word(tsum_s5[i] >>> qta_pkg::TRANS_FRAC_SHIFT);
			end
			rot_s6 <= rot_s5;
		end
	end

	assign out_valid = v_s6;
	assign rot_out = rot_s6;
	assign trans = trans_s6;

endmodule

`default_nettype wire

/* tb/sv/quaternion_to_affine_matrix_unit_test.sv */
// Self-checking stream testbench for the quaternion to affine matrix unit.
module quaternion_to_affine_matrix_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	// One slave-side word. Declared from the top bits down, so q_w lands in
	// bits 31:0 and centre_z in the highest 32 bits, as the port expects.
	typedef struct packed {
		qta_pkg::word_t centre_z;
		qta_pkg::word_t centre_y;
		qta_pkg::word_t centre_x;
		qta_pkg::word_t q_z;
		qta_pkg::word_t q_y;
		qta_pkg::word_t q_x;
		qta_pkg::word_t q_w;
	} pose_t;

	// One master-side word, element 0 in the lowest bits.
	typedef qta_pkg::word_t [11:0] affine_t;

	typedef enum int {
		ROT_00, ROT_01, ROT_02,
		ROT_10, ROT_11, ROT_12,
		ROT_20, ROT_21, ROT_22,
		TRANS_X, TRANS_Y, TRANS_Z,
		FIELD_COUNT
	} affine_field_e;

	// Wide enough for a doubled product sum and for the four-term translation sum.
	typedef logic signed [71:0] wide_t;

	localparam int unsigned ROT_SHIFT = 29;
	localparam int unsigned TRANS_SHIFT = 30;
	localparam int unsigned PIPE_LATENCY = 6;
	localparam int unsigned DRAIN_CYCLES = 4 * PIPE_LATENCY;
	localparam int unsigned RANDOM_PER_PHASE = 620;
	localparam int unsigned LONG_HOLD_CYCLES = 64;
	localparam qta_pkg::word_t Q_ONE = 32'sh4000_0000;
	// cos(45 degrees) in Q1.30, for quarter turns.
	localparam qta_pkg::word_t Q_HALF_SQRT2 = 32'sd759250125;
	localparam qta_pkg::word_t W_MAX = 32'sh7FFF_FFFF;
	localparam qta_pkg::word_t W_MIN = 32'sh8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	pose_t s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [qta_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	pose_t pose_queue[$];
	affine_t affine_queue[$];

	int unsigned sender_idle_pct = 12;
	int unsigned receiver_idle_pct = 87;
	int unsigned words_checked = 0;
	int unsigned error_count = 0;
	int unsigned hold_mark = 0;
	int unsigned hold_left = 0;
	bit long_hold_armed = 1'b0;
	bit long_hold_done = 1'b0;

	quaternion_to_affine_matrix_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Round half toward plus infinity at the given binary point, then clamp
	// to the 32-bit two's complement range.
	function automatic wide_t round_clamp(input wide_t s, input int unsigned k);
		wide_t q;
		q = (s + (wide_t'(1) <<< (k - 1))) >>> k;
		if (q > wide_t'(W_MAX)) begin
			q = wide_t'(W_MAX);
		end else if (q < wide_t'(W_MIN)) begin
			q = wide_t'(W_MIN);
		end
		return q;
	endfunction

	// Affine matrix for one pose, computed with exact wide products. The
	// translation uses the entries after their own rounding and clamping.
	function automatic affine_t affine_from_pose(input pose_t p);
		wide_t w, x, y, z;
		wide_t cen [3];
		wide_t rs [9];
		wide_t acc;
		wide_t tr;
		affine_t res;
		int row, col;
		w = $signed(p.q_w);
		x = $signed(p.q_x);
		y = $signed(p.q_y);
		z = $signed(p.q_z);
		cen[0] = $signed(p.centre_x);
		cen[1] = $signed(p.centre_y);
		cen[2] = $signed(p.centre_z);
		// Products are at 2^-60; shifting by 29 both doubles them and lands on Q1.30.
		rs[0] = round_clamp((wide_t'(1) <<< 59) - y * y - z * z, ROT_SHIFT);
		rs[1] = round_clamp(x * y - w * z, ROT_SHIFT);
		rs[2] = round_clamp(x * z + w * y, ROT_SHIFT);
		rs[3] = round_clamp(x * y + w * z, ROT_SHIFT);
		rs[4] = round_clamp((wide_t'(1) <<< 59) - x * x - z * z, ROT_SHIFT);
		rs[5] = round_clamp(y * z - w * x, ROT_SHIFT);
		rs[6] = round_clamp(x * z - w * y, ROT_SHIFT);
		rs[7] = round_clamp(y * z + w * x, ROT_SHIFT);
		rs[8] = round_clamp((wide_t'(1) <<< 59) - x * x - y * y, ROT_SHIFT);
		for (row = 0; row < 3; row++) begin
			res[ROT_00 + row * 3] = rs[row * 3][31:0];
			res[ROT_01 + row * 3] = rs[row * 3 + 1][31:0];
			res[ROT_02 + row * 3] = rs[row * 3 + 2][31:0];
			// Entry times centre is at 2^-46, so the centre is raised by 2^30 to match.
			acc = cen[row] <<< TRANS_SHIFT;
			for (col = 0; col < 3; col++) begin
				acc = acc - rs[row * 3 + col] * cen[col];
			end
			tr = round_clamp(acc, TRANS_SHIFT);
			res[TRANS_X + row] = tr[31:0];
		end
		return res;
	endfunction

	function automatic qta_pkg::word_t span_word(input int unsigned mag);
		return qta_pkg::word_t'($urandom_range(0, 2 * mag) - mag);
	endfunction

	function automatic qta_pkg::word_t corner_word();
		qta_pkg::word_t v;
		case ($urandom_range(0, 7))
			0: v = W_MAX;
			1: v = W_MIN;
			2: v = '0;
			3: v = Q_ONE;
			4: v = -Q_ONE;
			5: v = 32'sd1;
			6: v = -32'sd1;
			default: v = qta_pkg::word_t'($urandom);
		endcase
		return v;
	endfunction

	// Random pose. Some are quaternions of modest size with centres that stay
	// in range; the rest push products and translations into saturation.
	function automatic pose_t random_pose();
		pose_t p;
		qta_pkg::word_t qc [4];
		int lead, i;
		case ($urandom_range(0, 5))
			0: begin
				for (i = 0; i < 4; i++) qc[i] = qta_pkg::word_t'($urandom);
				p.centre_x = qta_pkg::word_t'($urandom);
				p.centre_y = qta_pkg::word_t'($urandom);
				p.centre_z = qta_pkg::word_t'($urandom);
			end
			1: begin
				// Norm at most one, so no rotation entry saturates.
				for (i = 0; i < 4; i++) qc[i] = span_word(32'h2000_0000);
				p.centre_x = span_word(32'h0100_0000);
				p.centre_y = span_word(32'h0100_0000);
				p.centre_z = span_word(32'h0100_0000);
			end
			2: begin
				for (i = 0; i < 4; i++) qc[i] = span_word(32'h4000_0000);
				p.centre_x = qta_pkg::word_t'($urandom);
				p.centre_y = qta_pkg::word_t'($urandom);
				p.centre_z = qta_pkg::word_t'($urandom);
			end
			3: begin
				// Close to a half turn about an axis, or to the identity.
				for (i = 0; i < 4; i++) qc[i] = span_word(32'h0010_0000);
				lead = $urandom_range(0, 3);
				qc[lead] = $urandom_range(0, 1) ? Q_ONE + qc[lead] : -Q_ONE + qc[lead];
				p.centre_x = span_word(32'h0010_0000);
				p.centre_y = span_word(32'h0010_0000);
				p.centre_z = span_word(32'h0010_0000);
			end
			4: begin
				for (i = 0; i < 4; i++) qc[i] = corner_word();
				p.centre_x = corner_word();
				p.centre_y = corner_word();
				p.centre_z = corner_word();
			end
			default: begin
				// Pure rotation about the origin.
				for (i = 0; i < 4; i++) qc[i] = span_word(32'h4000_0000);
				p.centre_x = '0;
				p.centre_y = '0;
				p.centre_z = '0;
			end
		endcase
		p.q_w = qc[0];
		p.q_x = qc[1];
		p.q_y = qc[2];
		p.q_z = qc[3];
		return p;
	endfunction

	task automatic queue_pose(input qta_pkg::word_t w, input qta_pkg::word_t x,
			input qta_pkg::word_t y, input qta_pkg::word_t z,
			input qta_pkg::word_t cx, input qta_pkg::word_t cy,
			input qta_pkg::word_t cz);
		pose_t p;
		p.q_w = w;
		p.q_x = x;
		p.q_y = y;
		p.q_z = z;
		p.centre_x = cx;
		p.centre_y = cy;
		p.centre_z = cz;
		pose_queue.push_back(p);
	endtask

	task automatic wait_sent();
		while (pose_queue.size() != 0 || s_axis_tvalid) @(negedge clk);
	endtask

	// Sender. A word stays on the bus until it is taken; the matrix it should
	// produce is queued at the edge that accepts it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				affine_queue.push_back(affine_from_pose(s_axis_tdata));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pose_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= pose_queue.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver. Besides random idling it can hold tready low for one long
	// stretch, long enough for the pipeline to fill and stall the sender.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left <= 0;
			long_hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (long_hold_armed && !long_hold_done && words_checked >= hold_mark) begin
			m_axis_tready <= 1'b0;
			hold_left <= LONG_HOLD_CYCLES;
			long_hold_done <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	// Checker. Every accepted matrix is compared field by field with the
	// oldest prediction.
	always @(posedge clk) begin : check_matrix
		affine_t got, want;
		affine_field_e fld;
		int unsigned bad;
		int i;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			bad = 0;
			got = m_axis_tdata;
			if (affine_queue.size() == 0) begin
				$error("matrix word %0d arrived with no pose waiting for it", words_checked);
				bad = 1;
			end else begin
				want = affine_queue.pop_front();
				for (i = 0; i < FIELD_COUNT; i++) begin
					if (got[i] !== want[i]) begin
						fld = affine_field_e'(i);
						$error("%s: expected %0d, got %0d", fld.name(), want[i], got[i]);
						bad++;
					end
				end
			end
			error_count <= error_count + bad;
			words_checked <= words_checked + 1;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Identity, with and without a centre; the translation must vanish.
		queue_pose(Q_ONE, 0, 0, 0, 0, 0, 0);
		queue_pose(Q_ONE, 0, 0, 0, W_MAX, W_MAX, W_MAX);
		queue_pose(-Q_ONE, 0, 0, 0, W_MIN, W_MIN, W_MIN);
		// The zero quaternion also gives the identity.
		queue_pose(0, 0, 0, 0, 32'sh0003_8000, -32'sh0001_0000, 32'sd1);
		// Half turns: the centre doubles on two axes and saturates at the extremes.
		queue_pose(0, Q_ONE, 0, 0, W_MAX, W_MAX, W_MAX);
		queue_pose(0, 0, Q_ONE, 0, W_MIN, W_MIN, W_MIN);
		queue_pose(0, 0, 0, -Q_ONE, 32'sh0001_0000, -32'sh0001_0000, 32'sh0003_0000);
		// Quarter turns about each axis, each about an off-origin centre.
		queue_pose(Q_HALF_SQRT2, 0, 0, Q_HALF_SQRT2, 32'sh0001_0000, 0, 0);
		queue_pose(Q_HALF_SQRT2, Q_HALF_SQRT2, 0, 0, 0, 32'sh0002_0000, -32'sh0001_0000);
		queue_pose(Q_HALF_SQRT2, 0, -Q_HALF_SQRT2, 0, 32'sh0010_0000, 32'sh0020_0000,
			32'sh0030_0000);
		// Far from unit length: entries saturate at both bounds.
		queue_pose(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX);
		queue_pose(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN);
		queue_pose(W_MAX, W_MIN, W_MIN, W_MIN, W_MAX, W_MIN, W_MAX);
		queue_pose(0, W_MIN, W_MIN, W_MIN, W_MIN, W_MAX, 0);
		queue_pose(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
			32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555);
		// Exact halves: x*y at half an LSB rounds up, minus half rounds to zero.
		queue_pose(0, 32'sd16384, 32'sd16384, 0, 0, 0, 0);
		queue_pose(0, 32'sd16384, -32'sd16384, 0, 0, 0, 0);
		// Half-length quaternion on x: the y and z scales drop to one half.
		queue_pose(0, 32'sh2000_0000, 0, 0, 32'sd1, 32'sd1, -32'sd1);
		queue_pose(Q_ONE, 0, 0, 0, 32'sd1, -32'sd1, 32'sd1);
		queue_pose(W_MAX, 0, 0, 0, W_MAX, W_MIN, 0);

		// The receiver is the bottleneck here.
		repeat (RANDOM_PER_PHASE) pose_queue.push_back(random_pose());
		wait_sent();

		// Now the sender is.
		sender_idle_pct = 87;
		receiver_idle_pct = 12;
		repeat (RANDOM_PER_PHASE) pose_queue.push_back(random_pose());
		wait_sent();

		// Full rate on both sides, with one long receiver stall early on.
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		hold_mark = words_checked + 30;
		long_hold_armed = 1'b1;
		repeat (RANDOM_PER_PHASE) pose_queue.push_back(random_pose());
		wait_sent();

		while (affine_queue.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (affine_queue.size() != 0) begin
			$error("%0d predicted matrices never arrived", affine_queue.size());
		end
		if (error_count == 0 && affine_queue.size() == 0) begin
			$display("quaternion_to_affine_matrix_unit regression: pass");
		end else begin
			$display("quaternion_to_affine_matrix_unit regression: fail");
		end
		$finish;
	end

	// A correct run takes well under a tenth of this.
	initial begin
		#5_000_000;
		$display("quaternion_to_affine_matrix_unit regression: fail");
		$finish;
	end

endmodule
